// ----- design/sfo_pkg.sv -----
package sfo_pkg;

    // Fixed sizes of the block.
    localparam int MAX_BINS    = 128;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int CNT_W       = BIN_W + 1;
    localparam int MAX_LAG     = 8;
    localparam int SLOT_W      = $clog2(MAX_LAG);
    localparam int HIST_AW     = SLOT_W + BIN_W;
    localparam int SAMPLE_BITS = 24;
    localparam int ENV_W       = 32;
    localparam int SUM_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic signed [SAMPLE_BITS:0] SAMPLE_MAX =
        (SAMPLE_BITS+1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [15:0] ALPHA_Q15 = 16'd32440;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MEL_BINS   = 3'd0;
    localparam logic [2:0] CFG_LAG_FRAMES = 3'd1;
    localparam logic [2:0] CFG_MAX_WINDOW = 3'd2;
    localparam logic [2:0] CFG_DETREND    = 3'd3;
    localparam logic [2:0] CFG_AGG_MODE   = 3'd4;

    // Configuration after clamping to the legal ranges.
    typedef struct packed {
        logic [CNT_W-1:0] nbins;
        logic [3:0]       lag;
        logic [2:0]       half;
        logic             detrend;
        logic             median;
    } t_cfg;

    // One classified bin request, front to back.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;
        logic                          clip;
        logic [BIN_W-1:0]              n;
        logic                          last;
    } t_bin_req;

endpackage

// ----- design/sfo_in_if.sv -----
interface sfo_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [sfo_pkg::SAMPLE_BITS-1:0]   bin_value;
    logic                                     clip_start;

    modport source (output valid, bin_value, clip_start, input ready);
    modport sink (input valid, bin_value, clip_start, output ready);
endinterface

// ----- design/sfo_out_if.sv -----
interface sfo_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sfo_pkg::ENV_W-1:0]   envelope;
    logic                               warmup;

    modport source (output valid, envelope, warmup, input ready);
    modport sink (input valid, envelope, warmup, output ready);
endinterface

// ----- design/sfo_front.sv -----
module sfo_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfo_pkg::t_cfg     i_cfg,
    sfo_in_if.sink            i_in,
    output sfo_pkg::t_bin_req o_req,
    output logic              o_req_valid,
    input  logic              i_req_pop
);
    import sfo_pkg::*;

    t_bin_req              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     r_wp;
    logic [QPTR_W-1:0]     r_rp;
    logic [QPTR_W:0]       r_cnt;
    logic [BIN_W-1:0]      r_bin;
    logic                  w_acc;
    logic                  w_pop;
    logic [BIN_W-1:0]      w_n;
    logic [CNT_W-1:0]      w_nxt;
    logic                  w_last;
    t_bin_req              w_req;

    assign i_in.ready  = (r_cnt != (QPTR_W+1)'(QUEUE_DEPTH));
    assign w_acc       = i_in.valid && i_in.ready;
    assign o_req_valid = (r_cnt != '0);
    assign w_pop       = i_req_pop && o_req_valid;
    assign o_req       = r_q[r_rp];

    // Tag each request with its bin index and whether it closes the frame.
    always_comb begin
        w_n    = i_in.clip_start ? '0 : r_bin;
        w_nxt  = {1'b0, w_n} + CNT_W'(1);
        w_last = (w_nxt >= i_cfg.nbins);
        w_req.x    = i_in.bin_value;
        w_req.clip = i_in.clip_start;
        w_req.n    = w_n;
        w_req.last = w_last;
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_req;
        end
    end

    // Queue pointers and bin counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_bin <= '0;
        end else begin
            if (w_acc) begin
                r_wp  <= r_wp + QPTR_W'(1);
                r_bin <= w_last ? '0 : w_nxt[BIN_W-1:0];
            end
            if (w_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (w_acc && !w_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (!w_acc && w_pop) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ----- design/sfo_back.sv -----
module sfo_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfo_pkg::t_cfg     i_cfg,
    input  sfo_pkg::t_bin_req i_req,
    input  logic              i_req_valid,
    output logic              o_req_pop,
    sfo_out_if.source         o_out
);
    import sfo_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_DIFF    = 15'b000000000000010,
        S_INS_RD  = 15'b000000000000100,
        S_INS_CMP = 15'b000000000001000,
        S_REF_RD  = 15'b000000000010000,
        S_REF_ACC = 15'b000000000100000,
        S_AGG     = 15'b000000001000000,
        S_MED_A   = 15'b000000010000000,
        S_MED_B   = 15'b000000100000000,
        S_MED_C   = 15'b000001000000000,
        S_DIV     = 15'b000010000000000,
        S_DIV_FIN = 15'b000100000000000,
        S_DET_MUL = 15'b001000000000000,
        S_DET_SUB = 15'b010000000000000,
        S_EMIT    = 15'b100000000000000
    } t_state;

    t_state                         r_state;
    logic signed [SAMPLE_BITS-1:0]  r_x;
    logic [BIN_W-1:0]               r_n;
    logic                           r_last;
    logic signed [SAMPLE_BITS-1:0]  r_d;
    logic [BIN_W-1:0]               r_i;
    logic [SUM_W-1:0]               r_sum;
    logic [SLOT_W-1:0]              r_slot;
    logic [3:0]                     r_seen;
    logic [BIN_W-1:0]               r_lastn;
    logic [BIN_W-1:0]               r_f;
    logic [BIN_W-1:0]               r_k;
    logic signed [SAMPLE_BITS-1:0]  r_m;
    logic signed [SAMPLE_BITS-1:0]  r_a;
    logic signed [ENV_W-1:0]        r_env;
    logic [CNT_W-1:0]               r_rem;
    logic [SUM_W-1:0]               r_quo;
    logic [4:0]                     r_step;
    logic signed [47:0]             r_prod;
    logic signed [ENV_W-1:0]        r_prev;
    logic                           r_warm;
    logic                           r_out_valid;
    logic signed [ENV_W-1:0]        r_out_env;
    logic                           r_out_warm;

    // Memories.
    logic signed [SAMPLE_BITS-1:0]  r_hist [MAX_LAG*MAX_BINS];
    logic signed [SAMPLE_BITS-1:0]  r_fbuf [MAX_BINS];
    logic signed [SAMPLE_BITS-1:0]  r_sort [MAX_BINS];
    logic signed [SAMPLE_BITS-1:0]  r_hist_rd;
    logic signed [SAMPLE_BITS-1:0]  r_fbuf_rd;
    logic signed [SAMPLE_BITS-1:0]  r_sort_rd;

    logic [HIST_AW-1:0]             w_hist_ra;
    logic                           w_hist_we;
    logic [HIST_AW-1:0]             w_hist_wa;
    logic                           w_fbuf_we;
    logic [BIN_W-1:0]               w_fbuf_ra;
    logic [BIN_W-1:0]               w_sort_ra;
    logic                           w_sort_we;
    logic [BIN_W-1:0]               w_sort_wa;
    logic signed [SAMPLE_BITS-1:0]  w_sort_wd;

    logic [SLOT_W-1:0]              w_slot_now;
    logic [CNT_W-1:0]               w_count;
    logic signed [SAMPLE_BITS:0]    w_dx;
    logic signed [SAMPLE_BITS-1:0]  w_d;
    logic                           w_gt;
    logic [BIN_W-1:0]               w_lo;
    logic [BIN_W-1:0]               w_lo_next;
    logic [BIN_W-1:0]               w_hi;
    logic [CNT_W-1:0]               w_fh;
    logic signed [SAMPLE_BITS-1:0]  w_max;
    logic [CNT_W:0]                 w_rem2;
    logic                           w_ge;
    logic signed [ENV_W:0]          w_tr;
    logic signed [ENV_W+1:0]        w_det;
    logic signed [ENV_W-1:0]        w_det_sat;
    logic                           w_emit;

    function automatic logic [BIN_W-1:0] low_edge(input logic [BIN_W-1:0] f,
                                                  input logic [2:0] h);
        logic [BIN_W-1:0] hw;
        hw = BIN_W'(h);
        return (f >= hw) ? (f - hw) : '0;
    endfunction

    assign o_req_pop = (r_state == S_IDLE) && i_req_valid;
    assign w_count   = {1'b0, r_lastn} + CNT_W'(1);
    assign w_emit    = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    // Difference against the reference bin, clamped to [0, SAMPLE_MAX].
    always_comb begin
        w_dx = {r_x[SAMPLE_BITS-1], r_x} - {r_hist_rd[SAMPLE_BITS-1], r_hist_rd};
        if (w_dx < 0) begin
            w_d = '0;
        end else if (w_dx > SAMPLE_MAX) begin
            w_d = SAMPLE_MAX[SAMPLE_BITS-1:0];
        end else begin
            w_d = w_dx[SAMPLE_BITS-1:0];
        end
    end

    // Max filter window edges for the current reference bin.
    always_comb begin
        w_lo      = low_edge(r_f, i_cfg.half);
        w_lo_next = low_edge(r_f + BIN_W'(1), i_cfg.half);
        w_fh      = {1'b0, r_f} + CNT_W'(i_cfg.half);
        w_hi      = (w_fh > {1'b0, r_lastn}) ? r_lastn : w_fh[BIN_W-1:0];
        w_max     = ((r_k == w_lo) || (r_fbuf_rd > r_m)) ? r_fbuf_rd : r_m;
    end

    // One restoring division step, detrend subtract and saturation.
    always_comb begin
        w_rem2 = {r_rem, r_quo[SUM_W-1]};
        w_ge   = (w_rem2 >= {1'b0, w_count});
        w_tr   = r_prod[47:15];
        w_det  = {{2{r_env[ENV_W-1]}}, r_env} - {w_tr[ENV_W], w_tr};
        if (w_det > (ENV_W+2)'($signed({1'b0, {(ENV_W-1){1'b1}}}))) begin
            w_det_sat = {1'b0, {(ENV_W-1){1'b1}}};
        end else if (w_det < -(ENV_W+2)'($signed({2'b01, {(ENV_W-1){1'b0}}}))) begin
            w_det_sat = {1'b1, {(ENV_W-1){1'b0}}};
        end else begin
            w_det_sat = w_det[ENV_W-1:0];
        end
    end

    // Memory addresses and write strobes.
    always_comb begin
        w_slot_now = i_req.clip ? '0 : r_slot;
        w_hist_ra  = {w_slot_now - i_cfg.lag[SLOT_W-1:0], i_req.n};
        w_hist_we  = (r_state == S_REF_ACC) && (r_k == w_hi);
        w_hist_wa  = {r_slot, r_f};
        w_fbuf_we  = o_req_pop;
        w_fbuf_ra  = r_k;
        w_gt       = (r_sort_rd > r_d);
        w_sort_we  = 1'b0;
        w_sort_wa  = r_i;
        w_sort_wd  = r_d;
        w_sort_ra  = r_i - BIN_W'(1);
        case (r_state)
            S_INS_RD: begin
                w_sort_we = (r_i == '0);
            end
            S_INS_CMP: begin
                w_sort_we = 1'b1;
                w_sort_wd = w_gt ? r_sort_rd : r_d;
            end
            S_MED_A: begin
                w_sort_ra = r_lastn >> 1;
            end
            S_MED_B: begin
                w_sort_ra = w_count[CNT_W-1:1];
            end
            default: begin
                w_sort_ra = r_i - BIN_W'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            r_hist[w_hist_wa] <= w_max;
        end
        r_hist_rd <= r_hist[w_hist_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_fbuf_we) begin
            r_fbuf[i_req.n] <= i_req.x;
        end
        r_fbuf_rd <= r_fbuf[w_fbuf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_sort_we) begin
            r_sort[w_sort_wa] <= w_sort_wd;
        end
        r_sort_rd <= r_sort[w_sort_ra];
    end

    // Sequencer for bin updates and frame-end work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_slot      <= '0;
            r_seen      <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_x    <= i_req.x;
                        r_n    <= i_req.n;
                        r_i    <= i_req.n;
                        r_last <= i_req.last;
                        if (i_req.clip) begin
                            r_sum  <= '0;
                            r_slot <= '0;
                            r_seen <= '0;
                            r_prev <= '0;
                        end
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_d     <= w_d;
                    r_sum   <= r_sum + SUM_W'(unsigned'(w_d));
                    r_state <= S_INS_RD;
                end
                S_INS_RD, S_INS_CMP: begin
                    if ((r_state == S_INS_RD) && (r_i != '0)) begin
                        r_state <= S_INS_CMP;
                    end else if ((r_state == S_INS_CMP) && w_gt) begin
                        r_i     <= r_i - BIN_W'(1);
                        r_state <= S_INS_RD;
                    end else if (r_last) begin
                        r_lastn <= r_n;
                        r_f     <= '0;
                        r_k     <= '0;
                        r_state <= S_REF_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_REF_RD: begin
                    r_state <= S_REF_ACC;
                end
                S_REF_ACC: begin
                    r_m <= w_max;
                    if (r_k == w_hi) begin
                        if (r_f == r_lastn) begin
                            r_state <= S_AGG;
                        end else begin
                            r_f     <= r_f + BIN_W'(1);
                            r_k     <= w_lo_next;
                            r_state <= S_REF_RD;
                        end
                    end else begin
                        r_k     <= r_k + BIN_W'(1);
                        r_state <= S_REF_RD;
                    end
                end
                S_AGG: begin
                    r_warm <= (r_seen < i_cfg.lag);
                    if (r_seen < i_cfg.lag) begin
                        r_env   <= '0;
                        r_state <= S_DET_MUL;
                    end else if (i_cfg.median) begin
                        r_state <= S_MED_A;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= r_sum;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_MED_A: begin
                    r_state <= S_MED_B;
                end
                S_MED_B: begin
                    r_a <= r_sort_rd;
                    if (w_count[0]) begin
                        r_env   <= ENV_W'(r_sort_rd);
                        r_state <= S_DET_MUL;
                    end else begin
                        r_state <= S_MED_C;
                    end
                end
                S_MED_C: begin
                    r_env   <= ENV_W'(({r_a[SAMPLE_BITS-1], r_a}
                               + {r_sort_rd[SAMPLE_BITS-1], r_sort_rd}) >>> 1);
                    r_state <= S_DET_MUL;
                end
                S_DIV: begin
                    r_rem  <= w_ge ? CNT_W'(w_rem2 - {1'b0, w_count}) : w_rem2[CNT_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], w_ge};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_state <= S_DIV_FIN;
                    end
                end
                S_DIV_FIN: begin
                    r_env   <= r_quo;
                    r_state <= S_DET_MUL;
                end
                S_DET_MUL: begin
                    if (i_cfg.detrend) begin
                        r_prod  <= $signed({1'b0, ALPHA_Q15}) * r_prev + 48'sd16384;
                        r_state <= S_DET_SUB;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DET_SUB: begin
                    r_env   <= w_det_sat;
                    r_prev  <= w_det_sat;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out_env   <= r_env;
                        r_out_warm  <= r_warm;
                        r_slot      <= r_slot + SLOT_W'(1);
                        r_sum       <= '0;
                        if (r_seen < 4'(MAX_LAG)) begin
                            r_seen <= r_seen + 4'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.envelope = r_out_env;
    assign o_out.warmup   = r_out_warm;

    // The insertion walk stays inside the bins already taken.
    a_ins_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> ((r_i != '0) && (r_i <= r_n)))
        else $error("insertion index out of range");

    // The max filter never reads past the last bin of the frame.
    a_ref_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REF_ACC) |-> ((r_k <= r_lastn) && (r_f <= r_lastn)))
        else $error("max filter index out of range");

    // The frame counter saturates at the history depth.
    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= 4'(MAX_LAG))
        else $error("frame counter beyond history depth");

    // A finished frame lands in the output register.
    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("frame result not loaded");

endmodule

// ----- design/spectral_flux_onset_envelope_unit.sv -----
// Spectral flux onset envelope.
// Input channel i_in carries one mel bin request per handshake (bin_value,
// signed Q16.8, and clip_start on the first bin of a clip). Output channel
// o_out carries one onset value per finished frame (envelope, Q24.8, and
// warmup). The plain write port i_cfg_* sets the five registers at any edge
// with i_cfg_we high; write only while the block is idle (not enforced).
// A four-entry request queue decouples the input from the bin processor, so
// bins are taken while an earlier bin or a frame end is still in progress.
// Per bin the processor forms the difference, then walks it down the
// sorted-difference memory, moving each greater entry up one place, so its
// time grows with the entries moved; a frame's first bin needs no compare.
// At frame end the max filter reads every window tap of each bin, then a
// restoring divider forms the mean, or the median is read from the sorted
// differences (warm-up gives zero and skips both), an optional detrend step
// follows, and the result is loaded into the output register.
// Reset clears the counters, the queue and the output valid; the memories
// are not cleared. A stalled receiver holds the result in the output
// register; the block keeps taking bins until the next result is due.
module spectral_flux_onset_envelope_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfo_in_if.sink      i_in,
    sfo_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import sfo_pkg::*;

    logic [7:0]  r_mel_bins;
    logic [3:0]  r_lag;
    logic [3:0]  r_window;
    logic        r_detrend;
    logic        r_median;
    t_cfg        w_cfg;
    t_bin_req    w_req;
    logic        w_req_valid;
    logic        w_req_pop;
    logic [3:0]  w_win;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mel_bins <= 8'd128;
            r_lag      <= 4'd1;
            r_window   <= 4'd1;
            r_detrend  <= 1'b0;
            r_median   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MEL_BINS:   r_mel_bins <= i_cfg_data;
                CFG_LAG_FRAMES: r_lag      <= i_cfg_data[3:0];
                CFG_MAX_WINDOW: r_window   <= i_cfg_data[3:0];
                CFG_DETREND:    r_detrend  <= i_cfg_data[0];
                CFG_AGG_MODE:   r_median   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the registers to their working ranges.
    always_comb begin
        w_win = (r_window == 4'd0) ? 4'd1 : r_window;
        if (r_mel_bins == 8'd0) begin
            w_cfg.nbins = CNT_W'(1);
        end else if (r_mel_bins > 8'(MAX_BINS)) begin
            w_cfg.nbins = CNT_W'(MAX_BINS);
        end else begin
            w_cfg.nbins = CNT_W'(r_mel_bins);
        end
        if (r_lag == 4'd0) begin
            w_cfg.lag = 4'd1;
        end else if (r_lag > 4'(MAX_LAG)) begin
            w_cfg.lag = 4'(MAX_LAG);
        end else begin
            w_cfg.lag = r_lag;
        end
        w_cfg.half    = w_win[3:1];
        w_cfg.detrend = r_detrend;
        w_cfg.median  = r_median;
    end

    sfo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in        (i_in),
        .o_req       (w_req),
        .o_req_valid (w_req_valid),
        .i_req_pop   (w_req_pop)
    );

    sfo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req       (w_req),
        .i_req_valid (w_req_valid),
        .o_req_pop   (w_req_pop),
        .o_out       (o_out)
    );

endmodule
